@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/mctb_pkg.sv @@
`timescale 1ns / 1ps

package mctb_pkg;

    localparam int DEF_NUM_TIMERS    = 8;
    localparam int DEF_INTERVAL_BITS = 16;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    localparam int ID_W      = 3;
    localparam int TICKS_W   = 16;
    localparam int ELAPSED_W = 16;
    localparam int COUNT_W   = 32;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_SET  = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FIRE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic eval;
        logic idx_clr;
        logic idx_inc;
        logic out_fire;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last_idx;
    } sts_t;

endpackage

@@ sv/multi_channel_countdown_timer_bank.sv @@
`timescale 1ns / 1ps

// Bank of NUM_TIMERS countdown timers with a 32-bit tick total that each tick
// item advances by its elapsed field. A set or read item is accepted, then
// answered by the closing transfer that carries the count. A tick item walks
// the timer memory one timer at a time, a read state then an evaluate state
// per timer, plus a fire state for each firing; fire and closing transfers
// wait for m_tready. Firings come out in ascending timer index, each with
// tuser high, ahead of the closing transfer with tlast high.
// A new item is taken only once the closing transfer has gone.

`include "assert_macros.svh"

module multi_channel_countdown_timer_bank #(
    parameter int NUM_TIMERS    = mctb_pkg::DEF_NUM_TIMERS,
    parameter int INTERVAL_BITS = mctb_pkg::DEF_INTERVAL_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // timer_id, ticks, repeat_req, elapsed, zero pad
    input  logic [mctb_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  logic [mctb_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fired_id, tick_total, zero pad
    output logic [mctb_pkg::M_TDATA_W-1:0]     m_tdata,
    // fired
    output logic [mctb_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast
);

    mctb_pkg::cmd_t cmd;
    mctb_pkg::sts_t sts;

    mctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    mctb_dp #(
        .NUM_TIMERS    (NUM_TIMERS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    `ASSERT_IMPL(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid)
    `ASSERT_IMPL(a_fire_not_last, aclk, aresetn, m_tvalid && m_tuser[0], !m_tlast)
    `ASSERT_NEXT(a_ready_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready)
    `ASSERT_NEXT(a_tick_scans, aclk, aresetn, s_tvalid && s_tready && (s_tuser == mctb_pkg::MODE_TICK), !m_tvalid && cmd.rd)

endmodule

@@ sv/mctb_ctrl.sv @@
`timescale 1ns / 1ps

module mctb_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mctb_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_tlast,
    input  mctb_pkg::sts_t                     sts,
    output mctb_pkg::cmd_t                     cmd
);

    mctb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mctb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mctb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == mctb_pkg::MODE_TICK) begin
                        state_next = mctb_pkg::ST_READ;
                    end else begin
                        state_next = mctb_pkg::ST_FINAL;
                    end
                end
            end
            mctb_pkg::ST_READ: begin
                state_next = mctb_pkg::ST_EVAL;
            end
            mctb_pkg::ST_EVAL: begin
                if (sts.hit) begin
                    state_next = mctb_pkg::ST_FIRE;
                end else if (sts.last_idx) begin
                    state_next = mctb_pkg::ST_FINAL;
                end else begin
                    state_next = mctb_pkg::ST_READ;
                end
            end
            mctb_pkg::ST_FIRE: begin
                if (m_tready) begin
                    state_next = sts.last_idx ? mctb_pkg::ST_FINAL : mctb_pkg::ST_READ;
                end
            end
            mctb_pkg::ST_FINAL: begin
                if (m_tready) begin
                    state_next = mctb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mctb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == mctb_pkg::ST_IDLE);
        m_tvalid     = (state_reg == mctb_pkg::ST_FIRE) || (state_reg == mctb_pkg::ST_FINAL);
        m_tlast      = (state_reg == mctb_pkg::ST_FINAL);
        cmd.accept   = (state_reg == mctb_pkg::ST_IDLE) && s_tvalid;
        cmd.rd       = (state_reg == mctb_pkg::ST_READ);
        cmd.eval     = (state_reg == mctb_pkg::ST_EVAL);
        cmd.idx_clr  = cmd.accept;
        cmd.idx_inc  = ((state_reg == mctb_pkg::ST_EVAL) && !sts.hit && !sts.last_idx)
                    || ((state_reg == mctb_pkg::ST_FIRE) && m_tready && !sts.last_idx);
        cmd.out_fire = (state_reg == mctb_pkg::ST_FIRE);
    end

endmodule

@@ sv/mctb_dp.sv @@
`timescale 1ns / 1ps

module mctb_dp #(
    parameter int NUM_TIMERS    = mctb_pkg::DEF_NUM_TIMERS,
    parameter int INTERVAL_BITS = mctb_pkg::DEF_INTERVAL_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [mctb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [mctb_pkg::S_TUSER_W-1:0]     s_tuser,
    input  mctb_pkg::cmd_t                     cmd,
    output mctb_pkg::sts_t                     sts,
    output logic [mctb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [mctb_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int EW     = (INTERVAL_BITS > mctb_pkg::ELAPSED_W) ? INTERVAL_BITS
                                                                 : mctb_pkg::ELAPSED_W;
    localparam int WORD_W = 2 * INTERVAL_BITS + 1;
    localparam int PAD_W  = mctb_pkg::M_TDATA_W - mctb_pkg::ID_W - mctb_pkg::COUNT_W;

    logic [mctb_pkg::ID_W-1:0]      in_id;
    logic [mctb_pkg::TICKS_W-1:0]   in_ticks;
    logic                           in_rep;
    logic [mctb_pkg::ELAPSED_W-1:0] in_elapsed;
    logic [INTERVAL_BITS-1:0]       ticks_cut;
    logic                           set_go;
    logic                           tick_go;

    // word: periodic, reload, remaining
    logic [WORD_W-1:0]              mem [NUM_TIMERS];
    logic [WORD_W-1:0]              rd_word_reg;
    logic [NUM_TIMERS-1:0]          armed_reg, armed_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [mctb_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [mctb_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [mctb_pkg::ID_W-1:0]      fid_reg;

    logic [INTERVAL_BITS-1:0]       cur_rem;
    logic [INTERVAL_BITS-1:0]       cur_rld;
    logic                           cur_per;
    logic                           cur_armed;
    logic                           hit;
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    logic [WORD_W-1:0]              wr_data;

    assign in_id      = s_tdata[2:0];
    assign in_ticks   = s_tdata[18:3];
    assign in_rep     = s_tdata[19];
    assign in_elapsed = s_tdata[35:20];
    assign ticks_cut  = INTERVAL_BITS'(in_ticks);

    assign set_go  = cmd.accept && (s_tuser == mctb_pkg::MODE_SET)
                  && (32'(in_id) < 32'(NUM_TIMERS));
    assign tick_go = cmd.accept && (s_tuser == mctb_pkg::MODE_TICK);

    assign cur_rem   = rd_word_reg[INTERVAL_BITS-1:0];
    assign cur_rld   = rd_word_reg[2*INTERVAL_BITS-1:INTERVAL_BITS];
    assign cur_per   = rd_word_reg[WORD_W-1];
    assign cur_armed = armed_reg[idx_reg];
    assign hit       = cur_armed && (EW'(elapsed_reg) >= EW'(cur_rem));

    assign sts.hit      = hit;
    assign sts.last_idx = (idx_reg == IDX_W'(NUM_TIMERS - 1));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_word_reg;
        if (set_go) begin
            wr_en   = (ticks_cut != '0);
            wr_addr = IDX_W'(in_id);
            wr_data = {in_rep, ticks_cut, ticks_cut};
        end else if (cmd.eval && cur_armed && (!hit || cur_per)) begin
            wr_en   = 1'b1;
            wr_data = {cur_per, cur_rld,
                       hit ? cur_rld : cur_rem - INTERVAL_BITS'(elapsed_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_word_reg <= mem[idx_reg];
        end
    end

    always_comb begin
        armed_next = armed_reg;
        if (set_go) begin
            armed_next[IDX_W'(in_id)] = (ticks_cut != '0);
        end else if (cmd.eval && hit && !cur_per) begin
            armed_next[idx_reg] = 1'b0;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign count_next = tick_go ? count_reg + mctb_pkg::COUNT_W'(in_elapsed) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
        end else begin
            armed_reg <= armed_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            elapsed_reg <= in_elapsed;
        end
        if (cmd.eval) begin
            fid_reg <= mctb_pkg::ID_W'(idx_reg);
        end
    end

    assign m_tuser = cmd.out_fire;
    assign m_tdata = {{PAD_W{1'b0}}, count_reg,
                      cmd.out_fire ? fid_reg : {mctb_pkg::ID_W{1'b0}}};

endmodule
